// ===== sv/sws_pkg.sv =====
// sws_pkg: shared types and constants for the sorting stack.
// Used by sws_cell, stack_with_sort and sws_chk; depends on nothing.
package sws_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int OPC_W  = 2;
	localparam int STS_W  = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_SORT = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// per-cell control for one cycle
	typedef struct packed {
		logic push;      // take word from the cell above
		logic pop;       // take word from the cell below
		logic keep_min;  // compare-exchange with the cell below, keep smaller
		logic keep_max;  // compare-exchange with the cell above, keep larger
	} cell_ctl_t;

endpackage

// ===== sv/sws_cell.sv =====
// sws_cell: one stack slot of the cell chain; shifts and compare-exchanges.
// Depends on sws_pkg.
module sws_cell (
	input  logic                              clk,
	input  sws_pkg::cell_ctl_t                ctl,
	input  logic signed [sws_pkg::DATA_W-1:0] up,
	input  logic signed [sws_pkg::DATA_W-1:0] down,
	output logic signed [sws_pkg::DATA_W-1:0] value
);

	logic signed [sws_pkg::DATA_W-1:0] value_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= up;
		end else if (ctl.pop) begin
			value_q <= down;
		end else if (ctl.keep_min && (down < value_q)) begin
			value_q <= down;
		end else if (ctl.keep_max && (up > value_q)) begin
			value_q <= up;
		end
	end

	assign value = value_q;

endmodule

// ===== sv/stack_with_sort.sv =====
// stack_with_sort: bounded LIFO of signed words with an in-place sort.
// Depends on sws_pkg and sws_cell.
//
// Usage
//   Input: an item (opcode, push_value) is taken at a clock edge with start
//   high and busy low. Output: each item gives exactly one result, shown on
//   pop_value/status/is_full/is_empty for one cycle with done high. The
//   receiver cannot stall; results are never held.
//   Config: cfg_we writes cfg_wdata into capacity (clamped to DEPTH when
//   used). Write only while idle.
// Structure
//   A chain of DEPTH cells, cell 0 is the top of the stack. Push shifts the
//   chain down, pop shifts it up.
//   Sort runs odd-even transposition: each cycle alternate neighbor pairs
//   inside the occupied part compare-exchange, smallest moving to the top.
// Timing
//   Push, pop, no-op: done in the cycle after accept; one item per cycle while not busy.
//   Sort: DEPTH exchange rounds with busy high, done on the cycle after the
//   last round.
// Reset
//   arst_n clears the count, the busy state and the strobe, and sets the
//   capacity to 16. Cell contents are not cleared; only occupied cells read.
module stack_with_sort #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command channel
	input  logic                              start,
	output logic                              busy,
	input  logic [sws_pkg::OPC_W-1:0]         opcode,
	input  logic signed [sws_pkg::DATA_W-1:0] push_value,
	// result channel
	output logic                              done,
	output logic signed [sws_pkg::DATA_W-1:0] pop_value,
	output logic [sws_pkg::STS_W-1:0]         status,
	output logic                              is_full,
	output logic                              is_empty,
	// configuration
	input  logic                              cfg_we,
	input  logic [sws_pkg::CAP_W-1:0]         cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > sws_pkg::CAP_W) ? CNT_W : sws_pkg::CAP_W;
	localparam int RND_W = $clog2(DEPTH);
	localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(DEPTH);
	localparam logic [RND_W-1:0] LAST_RND  = RND_W'(DEPTH - 1);

	logic [sws_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      sort_q;
	logic [RND_W-1:0]          rnd_q;

	logic                              done_q;
	logic signed [sws_pkg::DATA_W-1:0] pop_value_q;
	logic [sws_pkg::STS_W-1:0]         status_q;
	logic                              is_full_q;
	logic                              is_empty_q;

	logic signed [sws_pkg::DATA_W-1:0] cell_val [DEPTH];
	sws_pkg::cell_ctl_t                cell_ctl [DEPTH];
	logic [DEPTH-1:0]                  pair_en;   // bit i: pair (i, i+1) exchanges

	logic [CMP_W-1:0] cap_raw;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] cnt_nxt_ext;
	logic [CNT_W-1:0] cnt_nxt;
	logic             acc;
	logic             push_ok;
	logic             pop_ok;
	logic             sort_go;
	logic             sort_end;
	logic             finish;
	sws_pkg::status_t sts_nxt;

	always_comb begin
		cap_raw = CMP_W'(capacity_q);
		cap_eff = (cap_raw > DEPTH_C) ? DEPTH_C : cap_raw;
		cnt_ext = CMP_W'(cnt_q);
		acc     = start && !sort_q;
		push_ok = acc && (opcode == sws_pkg::OP_PUSH) && (cnt_ext < cap_eff);
		pop_ok  = acc && (opcode == sws_pkg::OP_POP) && (cnt_q != '0);
		sort_go = acc && (opcode == sws_pkg::OP_SORT);
		sort_end = sort_q && (rnd_q == LAST_RND);
		// a sort result waits for the last round, everything else is immediate
		finish  = (acc && (opcode != sws_pkg::OP_SORT)) || sort_end;

		cnt_nxt = cnt_q;
		if (push_ok) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (pop_ok) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
		cnt_nxt_ext = CMP_W'(cnt_nxt);

		sts_nxt = sws_pkg::ST_OK;
		if (acc && (opcode == sws_pkg::OP_PUSH) && !push_ok) begin
			sts_nxt = sws_pkg::ST_FULL;
		end else if (acc && (opcode == sws_pkg::OP_POP) && !pop_ok) begin
			sts_nxt = sws_pkg::ST_EMPTY;
		end
	end

	// pair (i, i+1) is active in rounds of matching parity, only inside the
	// occupied part of the chain
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_pair
			if (gi < DEPTH - 1) begin : g_act
				localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(gi + 1);
				localparam logic             PAR      = 1'(gi % 2);
				assign pair_en[gi] = sort_q && (rnd_q[0] == PAR) && (NEXT_IDX < cnt_q);
			end else begin : g_last
				assign pair_en[gi] = 1'b0;
			end
		end
	endgenerate

	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [sws_pkg::DATA_W-1:0] up_w;
			logic signed [sws_pkg::DATA_W-1:0] down_w;

			if (gi == 0) begin : g_top
				assign up_w                 = push_value;
				assign cell_ctl[gi].keep_max = 1'b0;
			end else begin : g_mid
				assign up_w                 = cell_val[gi-1];
				assign cell_ctl[gi].keep_max = pair_en[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_bot
				assign down_w = '0;
			end else begin : g_nbot
				assign down_w = cell_val[gi+1];
			end

			assign cell_ctl[gi].push     = push_ok;
			assign cell_ctl[gi].pop      = pop_ok;
			assign cell_ctl[gi].keep_min = pair_en[gi];

			sws_cell u_cell (
				.clk   (clk),
				.ctl   (cell_ctl[gi]),
				.up    (up_w),
				.down  (down_w),
				.value (cell_val[gi])
			);
		end
	endgenerate

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= sws_pkg::CAP_RESET;
			cnt_q      <= '0;
			sort_q     <= 1'b0;
			rnd_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			cnt_q  <= cnt_nxt;
			done_q <= finish;
			if (sort_go) begin
				sort_q <= 1'b1;
				rnd_q  <= '0;
			end else if (sort_end) begin
				sort_q <= 1'b0;
			end else if (sort_q) begin
				rnd_q <= rnd_q + RND_W'(1);
			end
		end
	end

	// result registers, loaded when an item completes
	always_ff @(posedge clk) begin
		if (finish) begin
			pop_value_q <= pop_ok ? cell_val[0] : '0;
			status_q    <= sts_nxt;
			is_full_q   <= (cnt_nxt_ext >= cap_eff);
			is_empty_q  <= (cnt_nxt == '0);
		end
	end

	assign busy      = sort_q;
	assign done      = done_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign is_full   = is_full_q;
	assign is_empty  = is_empty_q;

endmodule

// ===== sv/sws_chk.sv =====
// sws_chk: port-level checks for stack_with_sort, bound to the top level.
// Depends on sws_pkg.
module sws_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [sws_pkg::OPC_W-1:0]         opcode,
	input logic                              done,
	input logic signed [sws_pkg::DATA_W-1:0] pop_value,
	input logic [sws_pkg::STS_W-1:0]         status,
	input logic                              is_full,
	input logic                              is_empty
);

	// non-sort items answer on the next cycle
	a_fast_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode != sws_pkg::OP_SORT)) |=> done)
		else $error("missing result one cycle after push/pop");

	// no result while a sort is still running
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy && done))
		else $error("result strobe during sort");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == sws_pkg::ST_FULL)) |-> is_full)
		else $error("push refused but not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == sws_pkg::ST_EMPTY)) |-> (is_empty && (pop_value == '0)))
		else $error("pop refused but stack not empty or value nonzero");

	a_sort_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == sws_pkg::OP_SORT)) |=> (busy && !done))
		else $error("sort did not raise busy");

endmodule

bind stack_with_sort sws_chk u_sws_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.opcode    (opcode),
	.done      (done),
	.pop_value (pop_value),
	.status    (status),
	.is_full   (is_full),
	.is_empty  (is_empty)
);
